// ----- design/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// cbd_pkg - shared types and constants for the chunked body decoder
// Phase and status codes, framing characters, the result bundle and the
// hex digit decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Most size characters one chunk header may carry
  localparam int unsigned MaxSizeDigits = 16;
  localparam int unsigned DigitCountW   = 5;
  localparam int unsigned SizeW         = 64;

  // Framing characters
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_SIZE   = 3'd0,
    PH_SIZELF = 3'd1,
    PH_DATA   = 3'd2,
    PH_TCR    = 3'd3,
    PH_TLF    = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERR    = 3'd6
  } phase_t;

  // Result status codes
  typedef enum logic [3:0] {
    ST_FRAME   = 4'd0,
    ST_PAYLOAD = 4'd1,
    ST_DONE    = 4'd2,
    ST_AFTER   = 4'd3,
    ST_BADSIZE = 4'd4,
    ST_TOOLONG = 4'd5,
    ST_BADFRM  = 4'd6,
    ST_RESTART = 4'd7,
    ST_AFTERR  = 4'd8
  } status_t;

  // One result item
  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
  } result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- design/cbd_fsm.sv -----
// ----------------------------------------------------------------------------
// cbd_fsm - chunk framing state machine
// Holds the phase, size accumulator and payload down-counter, and works out
// the result of one body byte combinationally.
// ----------------------------------------------------------------------------
module cbd_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,       // consume one transaction this cycle
  input  logic             action,     // 1 = restart
  input  logic [7:0]       data_byte,
  output cbd_pkg::result_t result
);

  cbd_pkg::phase_t phase, phase_next;
  logic [cbd_pkg::SizeW-1:0]       size_accum, size_accum_next;
  logic [cbd_pkg::DigitCountW-1:0] digit_count, digit_count_next;
  logic                            nonhex_seen, nonhex_seen_next;
  logic [cbd_pkg::SizeW-1:0]       bytes_left, bytes_left_next;

  logic [4:0]                hex;
  logic                      is_cr, is_lf, size_full, size_empty;
  logic [cbd_pkg::SizeW-1:0] left_after;

  // Byte classification and payload count-down
  always_comb begin
    hex        = cbd_pkg::hex_decode(data_byte);
    is_cr      = (data_byte == cbd_pkg::CharCr);
    is_lf      = (data_byte == cbd_pkg::CharLf);
    size_full  = (digit_count >= cbd_pkg::DigitCountW'(cbd_pkg::MaxSizeDigits));
    size_empty = (digit_count == '0) || nonhex_seen;
    left_after = (bytes_left != '0) ? bytes_left - 1'b1 : '0;
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (action) begin
      phase_next = cbd_pkg::PH_SIZE;
    end else begin
      case (phase)
        cbd_pkg::PH_SIZE: begin
          if (is_cr) begin
            phase_next = size_empty ? cbd_pkg::PH_ERR : cbd_pkg::PH_SIZELF;
          end else if (size_full) begin
            phase_next = cbd_pkg::PH_ERR;
          end
        end
        cbd_pkg::PH_SIZELF: begin
          if (!is_lf) begin
            phase_next = cbd_pkg::PH_ERR;
          end else if (bytes_left == '0) begin
            phase_next = cbd_pkg::PH_DONE;
          end else begin
            phase_next = cbd_pkg::PH_DATA;
          end
        end
        cbd_pkg::PH_DATA: begin
          if (left_after == '0) begin
            phase_next = cbd_pkg::PH_TCR;
          end
        end
        cbd_pkg::PH_TCR: begin
          phase_next = is_cr ? cbd_pkg::PH_TLF : cbd_pkg::PH_ERR;
        end
        cbd_pkg::PH_TLF: begin
          phase_next = is_lf ? cbd_pkg::PH_SIZE : cbd_pkg::PH_ERR;
        end
        cbd_pkg::PH_DONE: begin
          phase_next = cbd_pkg::PH_DONE;
        end
        default: begin
          phase_next = cbd_pkg::PH_ERR;
        end
      endcase
    end
  end

  // Result and datapath updates
  always_comb begin
    result.status       = cbd_pkg::ST_FRAME;
    result.payload_byte = 8'd0;
    size_accum_next     = size_accum;
    digit_count_next    = digit_count;
    nonhex_seen_next    = nonhex_seen;
    bytes_left_next     = bytes_left;
    if (action) begin
      result.status    = cbd_pkg::ST_RESTART;
      size_accum_next  = '0;
      digit_count_next = '0;
      nonhex_seen_next = 1'b0;
      bytes_left_next  = '0;
    end else begin
      case (phase)
        cbd_pkg::PH_SIZE: begin
          if (is_cr) begin
            if (size_empty) begin
              result.status = cbd_pkg::ST_BADSIZE;
            end else begin
              bytes_left_next  = size_accum;
              size_accum_next  = '0;
              digit_count_next = '0;
              nonhex_seen_next = 1'b0;
            end
          end else if (size_full) begin
            result.status = cbd_pkg::ST_TOOLONG;
          end else begin
            digit_count_next = digit_count + 1'b1;
            if (!hex[4]) begin
              nonhex_seen_next = 1'b1;
            end else begin
              size_accum_next = {size_accum[cbd_pkg::SizeW-5:0], hex[3:0]};
            end
          end
        end
        cbd_pkg::PH_SIZELF: begin
          if (!is_lf) begin
            result.status = cbd_pkg::ST_BADFRM;
          end else if (bytes_left == '0) begin
            result.status = cbd_pkg::ST_DONE;
          end
        end
        cbd_pkg::PH_DATA: begin
          result.status       = cbd_pkg::ST_PAYLOAD;
          result.payload_byte = data_byte;
          bytes_left_next     = left_after;
        end
        cbd_pkg::PH_TCR: begin
          if (!is_cr) result.status = cbd_pkg::ST_BADFRM;
        end
        cbd_pkg::PH_TLF: begin
          if (!is_lf) result.status = cbd_pkg::ST_BADFRM;
        end
        cbd_pkg::PH_DONE: begin
          result.status = cbd_pkg::ST_AFTER;
        end
        default: begin
          result.status = cbd_pkg::ST_AFTERR;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cbd_pkg::PH_SIZE;
      size_accum  <= '0;
      digit_count <= '0;
      nonhex_seen <= 1'b0;
      bytes_left  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      size_accum  <= size_accum_next;
      digit_count <= digit_count_next;
      nonhex_seen <= nonhex_seen_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

// ----- design/chunked_body_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// chunked_body_decoder_unit - chunked HTTP body deframer
// Byte stream in, one status-tagged result per byte out.
// ----------------------------------------------------------------------------
// Takes one byte of a chunked body per cycle unless the result side stalls, and
// returns exactly one result transaction per input transaction, in order: a
// payload byte (status 1), a framing note, or an error/end code in tuser. A
// transaction with tuser set restarts the decoder for a new body. Throughput
// is one byte per clock with no bubbles while m_axis_tready holds; the path
// from input to result runs through the input register, then the result
// register. The state update in cbd_fsm handles the size digit shift and the
// 64-bit payload count-down in one step. Errors are sticky until a restart.
module chunked_body_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] action (1 = restart)
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [3:0] m_axis_tuser    // [3:0] status
);

  logic             in_valid;
  logic             in_action;
  logic [7:0]       in_byte;
  logic             advance;
  cbd_pkg::result_t result;

  // Pipeline moves whenever the result register is free or being drained
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= s_axis_tuser;
      in_byte   <= s_axis_tdata;
    end
  end

  // Framing state machine
  cbd_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (in_valid && advance),
    .action    (in_action),
    .data_byte (in_byte),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_axis_tdata <= result.payload_byte;
      m_axis_tuser <= result.status;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for chunked_body_decoder_unit
// Drives a chunked body byte stream through the decoder with random idling
// on both sides. A short directed table covers restart, the data extremes and
// every status code but size too long, which the random part reaches. A
// random part of mostly well-formed bodies with broken ones mixed in follows.
// Every result transaction is checked against a fixed directed row's own result
// or against an in-bench copy of the decoder state machine.
// ----------------------------------------------------------------------------
module testbench;
  import cbd_pkg::*;

  localparam int RandomItems = 1450;
  localparam int HoldAt      = 500;   // input index that starts the long stall
  localparam int PauseAt     = 1000;  // input index where the sender drains
  localparam int LongHold    = 300;
  localparam int IdleLimit   = 3000;
  localparam int DrainCycles = 8;

  // Directed stimulus row; a fixed row carries its own expected result
  typedef struct packed {
    logic       act;
    logic [7:0] data;
    logic       fixed;
    status_t    st;
    logic [7:0] pay;
  } dir_row_t;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
  } body_item_t;

  localparam dir_row_t DirRows [24] = '{
    '{1'b1, 8'h00, 1'b1, ST_RESTART, 8'h00},
    '{1'b0, CharCr, 1'b1, ST_BADSIZE, 8'h00},  // empty size
    '{1'b0, 8'hFF, 1'b1, ST_AFTERR, 8'h00},
    '{1'b1, 8'hFF, 1'b1, ST_RESTART, 8'h00},   // data ignored on restart
    '{1'b0, 8'h30, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, 8'h32, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, CharCr, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, CharLf, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, 8'h00, 1'b1, ST_PAYLOAD, 8'h00},
    '{1'b0, 8'hFF, 1'b1, ST_PAYLOAD, 8'hFF},
    '{1'b0, CharCr, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, CharLf, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, 8'h30, 1'b0, ST_FRAME, 8'h00},     // last chunk
    '{1'b0, CharCr, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, CharLf, 1'b1, ST_DONE, 8'h00},
    '{1'b0, 8'h41, 1'b1, ST_AFTER, 8'h00},
    '{1'b1, 8'h00, 1'b1, ST_RESTART, 8'h00},
    '{1'b0, 8'h67, 1'b0, ST_FRAME, 8'h00},     // non-hex size char
    '{1'b0, CharCr, 1'b1, ST_BADSIZE, 8'h00},
    '{1'b1, 8'h00, 1'b1, ST_RESTART, 8'h00},
    '{1'b0, 8'h66, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, CharCr, 1'b0, ST_FRAME, 8'h00},
    '{1'b0, 8'h00, 1'b1, ST_BADFRM, 8'h00},    // LF missing after size
    '{1'b1, 8'h00, 1'b1, ST_RESTART, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tuser = 1'b0;    // [0] action (1 = restart)
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] payload_byte
  logic [3:0] m_axis_tuser;           // [3:0] status

  // Side channel for fixed expectations of the directed rows
  logic       cur_fixed = 1'b0;
  status_t    cur_st = ST_FRAME;
  logic [7:0] cur_pay = 8'h00;

  body_item_t stim_q [$];
  result_t    expect_q [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  // Decoder state mirror
  phase_t      dec_phase;
  logic [63:0] size_acc;
  logic [4:0]  digit_cnt;
  logic        nonhex_flag;
  logic [63:0] bytes_due;

  chunked_body_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hex digit value, -1 for anything else
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  function automatic void clear_decoder();
    dec_phase   = PH_SIZE;
    size_acc    = '0;
    digit_cnt   = '0;
    nonhex_flag = 1'b0;
    bytes_due   = '0;
  endfunction

  // Advance the mirror by one byte and return the result it causes
  function automatic result_t decode_byte(input logic act, input logic [7:0] b);
    result_t r;
    int      hv;
    r.status       = ST_FRAME;
    r.payload_byte = 8'h00;
    if (act) begin
      clear_decoder();
      r.status = ST_RESTART;
    end else begin
      case (dec_phase)
        PH_SIZE: begin
          if (b == CharCr) begin
            if (digit_cnt == 0 || nonhex_flag) begin
              dec_phase = PH_ERR;
              r.status  = ST_BADSIZE;
            end else begin
              bytes_due   = size_acc;
              size_acc    = '0;
              digit_cnt   = '0;
              nonhex_flag = 1'b0;
              dec_phase   = PH_SIZELF;
            end
          end else if (digit_cnt >= MaxSizeDigits) begin
            dec_phase = PH_ERR;
            r.status  = ST_TOOLONG;
          end else begin
            hv        = nibble_of(b);
            digit_cnt = digit_cnt + 5'd1;
            if (hv < 0) nonhex_flag = 1'b1;
            else size_acc = {size_acc[59:0], 4'(hv)};
          end
        end
        PH_SIZELF: begin
          if (b != CharLf) begin
            dec_phase = PH_ERR;
            r.status  = ST_BADFRM;
          end else if (bytes_due == 0) begin
            dec_phase = PH_DONE;
            r.status  = ST_DONE;
          end else begin
            dec_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          r.payload_byte = b;
          r.status       = ST_PAYLOAD;
          if (bytes_due != 0) bytes_due = bytes_due - 64'd1;
          if (bytes_due == 0) dec_phase = PH_TCR;
        end
        PH_TCR: begin
          if (b != CharCr) begin
            dec_phase = PH_ERR;
            r.status  = ST_BADFRM;
          end else begin
            dec_phase = PH_TLF;
          end
        end
        PH_TLF: begin
          if (b != CharLf) begin
            dec_phase = PH_ERR;
            r.status  = ST_BADFRM;
          end else begin
            dec_phase = PH_SIZE;
          end
        end
        PH_DONE: r.status = ST_AFTER;
        default: begin
          dec_phase = PH_ERR;
          r.status  = ST_AFTERR;
        end
      endcase
    end
    return r;
  endfunction

  // ---- random stimulus construction ----
  function automatic void push_byte(input logic [7:0] b);
    stim_q.push_back('{act: 1'b0, data: b});
  endfunction

  function automatic void push_restart();
    stim_q.push_back('{act: 1'b1, data: 8'($urandom_range(255))});
  endfunction

  // Hex digit character, random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    if ($urandom_range(1) != 0) return 8'h41 + v - 8'd10;
    return 8'h61 + v - 8'd10;
  endfunction

  function automatic logic [7:0] nonhex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (nibble_of(b) >= 0 || b == CharCr);
    return b;
  endfunction

  function automatic logic [7:0] wrong_byte(input logic [7:0] good);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == good) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [63:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 64'($urandom_range(1, 6));
    if (r < 97) return 64'($urandom_range(7, 40));
    return 64'($urandom_range(100, 260));
  endfunction

  // Size digits, sometimes with leading zeros up to the full 16
  function automatic void push_size(input logic [63:0] sz);
    int         ndig;
    int         pad;
    logic [63:0] rest;
    ndig = 1;
    rest = sz >> 4;
    while (rest != 0) begin
      ndig++;
      rest = rest >> 4;
    end
    if ($urandom_range(7) == 0) pad = MaxSizeDigits - ndig;
    else pad = $urandom_range(0, (MaxSizeDigits - ndig < 2) ? MaxSizeDigits - ndig : 2);
    repeat (pad) push_byte(8'h30);
    for (int i = ndig - 1; i >= 0; i--) push_byte(hex_char(sz[4*i +: 4]));
  endfunction

  function automatic void push_chunk(input logic [63:0] sz);
    push_size(sz);
    push_byte(CharCr);
    push_byte(CharLf);
    repeat (sz) push_byte(8'($urandom_range(255)));
    push_byte(CharCr);
    push_byte(CharLf);
  endfunction

  function automatic void build_random_stimulus();
    int          n;
    int          k;
    logic [63:0] sz;
    while (stim_q.size() < RandomItems) begin
      if ($urandom_range(99) < 72) begin
        // well-formed body, then a few bytes past its end
        if ($urandom_range(9) != 0) push_restart();
        repeat ($urandom_range(1, 4)) push_chunk(pick_size());
        push_size(64'd0);
        push_byte(CharCr);
        push_byte(CharLf);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)));
      end else begin
        push_restart();
        case ($urandom_range(6))
          0: begin  // one to three size chars too many
            repeat (MaxSizeDigits + $urandom_range(1, 3))
              push_byte(hex_char(4'($urandom_range(15))));
          end
          1: begin  // non-hex char in the size
            n = $urandom_range(1, 4);
            k = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
              push_byte((i == k) ? nonhex_byte() : hex_char(4'($urandom_range(15))));
            push_byte(CharCr);
          end
          2: push_byte(CharCr);
          3: begin  // LF missing after size
            push_size(pick_size());
            push_byte(CharCr);
            push_byte(wrong_byte(CharLf));
          end
          4: begin  // bad trailer after payload
            sz = 64'($urandom_range(1, 6));
            push_size(sz);
            push_byte(CharCr);
            push_byte(CharLf);
            repeat (sz) push_byte(8'($urandom_range(255)));
            if ($urandom_range(1) != 0) begin
              push_byte(wrong_byte(CharCr));
            end else begin
              push_byte(CharCr);
              push_byte(wrong_byte(CharLf));
            end
          end
          5: begin  // 16-digit size, cut short by the next restart
            sz     = {32'($urandom), 32'($urandom)};
            sz[63] = 1'b1;
            push_size(sz);
            push_byte(CharCr);
            push_byte(CharLf);
            repeat ($urandom_range(5, 20)) push_byte(8'($urandom_range(255)));
          end
          default: ;
        endcase
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Present one transaction and hold it until accepted; returns at a falling edge
  task automatic send_item(input logic act, input logic [7:0] b, input logic fixed,
                           input status_t st, input logic [7:0] pay);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    cur_fixed     <= fixed;
    cur_st        <= st;
    cur_pay       <= pay;
    do @(posedge clk);
    while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Predict on input transactions, check on output transactions
  always @(posedge clk) begin : scoreboard
    result_t pred;
    result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = decode_byte(s_axis_tuser, s_axis_tdata);
        if (cur_fixed) expect_q.push_back('{status: cur_st, payload_byte: cur_pay});
        else expect_q.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expect_q.size() == 0) begin
          report_mismatch("unexpected result status", int'(m_axis_tuser), -1);
        end else begin
          want = expect_q.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", int'(m_axis_tuser), int'(want.status));
          if (m_axis_tdata != want.payload_byte)
            report_mismatch("payload_byte", int'(m_axis_tdata), int'(want.payload_byte));
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: ready runs and stalls, plus one long hold-off
  initial begin : drive_ready
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
          end
          6, 7, 8: begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
          end
          default: begin
            m_axis_tready <= 1'($urandom_range(1));
            @(negedge clk);
          end
        endcase
      end
    end
  end

  // Sender: directed table, then random bursts with gaps
  initial begin : drive_input
    int idx;
    int burst;
    int gap;
    bit pause_now;
    bit paused;
    paused = 1'b0;
    clear_decoder();
    build_random_stimulus();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DirRows[i])
      send_item(DirRows[i].act, DirRows[i].data, DirRows[i].fixed, DirRows[i].st,
                DirRows[i].pay);

    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < stim_q.size()) begin
        send_item(stim_q[idx].act, stim_q[idx].data, 1'b0, ST_FRAME, 8'h00);
        idx++;
        burst--;
        if (idx == HoldAt) hold_req = 1'b1;
      end
      pause_now = (idx >= PauseAt) && !paused;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (hold_req && !hold_done) gap = 0;  // keep offering while output is held
      if (pause_now && gap == 0) gap = 1;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (pause_now) begin
          paused = 1'b1;
          while (expect_q.size() != 0) @(negedge clk);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expect_q.size() != 0)
      report_mismatch("results never delivered", expect_q.size(), 0);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
